### rtl/core/mprg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mprg_pkg: shared definitions for the middle-product random generator
// Field widths, configuration register indexes, the power-of-ten table and
// the control store of the microcoded sequencer.
// ----------------------------------------------------------------------------
package mprg_pkg;

  // Field widths
  localparam int unsigned SEED_W    = 30;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned PROD_W    = 60;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 30;

  // Default for the largest supported digit count
  localparam int unsigned MAX_DIGITS_DEF = 9;

  // Binary-to-BCD conversion: product bits shifted per sequencer step
  localparam int unsigned DABBLE_BITS  = 4;
  localparam int unsigned DABBLE_STEPS = PROD_W / DABBLE_BITS;
  localparam int unsigned CNT_W        = $clog2(DABBLE_STEPS + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [SEED_W-1:0]  FIRST_SEED_RST  = 30'd1234;
  localparam logic [SEED_W-1:0]  SECOND_SEED_RST = 30'd5678;
  localparam logic [DIGIT_W-1:0] DIGIT_COUNT_RST = 4'd4;

  // Datapath operations selected by a control word
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_CLEAR   = 4'd1,
    OP_MUL     = 4'd2,
    OP_DABBLE  = 4'd3,
    OP_LEN     = 4'd4,
    OP_COLLECT = 4'd5,
    OP_SHIFT   = 4'd6,
    OP_ERR     = 4'd7,
    OP_RESTART = 4'd8,
    OP_EMIT    = 4'd9
  } op_t;

  // Jump conditions; a true condition loads the target, else the step advances
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_INPUT = 3'd2,
    C_RESTART  = 3'd3,
    C_NOGO     = 3'd4,
    C_LOOP     = 3'd5,
    C_OUT_FREE = 3'd6
  } cond_t;

  localparam int unsigned PC_W = 4;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
  } uword_t;

  // Program step addresses
  localparam logic [PC_W-1:0] S_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] S_CLEAR   = 4'd1;
  localparam logic [PC_W-1:0] S_CHECK   = 4'd2;
  localparam logic [PC_W-1:0] S_MUL     = 4'd3;
  localparam logic [PC_W-1:0] S_DABBLE  = 4'd4;
  localparam logic [PC_W-1:0] S_LEN     = 4'd5;
  localparam logic [PC_W-1:0] S_COLLECT = 4'd6;
  localparam logic [PC_W-1:0] S_SHIFT   = 4'd7;
  localparam logic [PC_W-1:0] S_FAIL    = 4'd8;
  localparam logic [PC_W-1:0] S_LOAD    = 4'd9;
  localparam logic [PC_W-1:0] S_EMIT    = 4'd10;
  localparam logic [PC_W-1:0] S_HOLD    = 4'd11;

  // Control store
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      S_WAIT:    w = '{op: OP_NONE,    cond: C_NO_INPUT, tgt: S_WAIT};
      S_CLEAR:   w = '{op: OP_CLEAR,   cond: C_RESTART,  tgt: S_LOAD};
      S_CHECK:   w = '{op: OP_NONE,    cond: C_NOGO,     tgt: S_FAIL};
      S_MUL:     w = '{op: OP_MUL,     cond: C_NEVER,    tgt: S_WAIT};
      S_DABBLE:  w = '{op: OP_DABBLE,  cond: C_LOOP,     tgt: S_DABBLE};
      S_LEN:     w = '{op: OP_LEN,     cond: C_NEVER,    tgt: S_WAIT};
      S_COLLECT: w = '{op: OP_COLLECT, cond: C_LOOP,     tgt: S_COLLECT};
      S_SHIFT:   w = '{op: OP_SHIFT,   cond: C_ALWAYS,   tgt: S_EMIT};
      S_FAIL:    w = '{op: OP_ERR,     cond: C_ALWAYS,   tgt: S_EMIT};
      S_LOAD:    w = '{op: OP_RESTART, cond: C_NEVER,    tgt: S_WAIT};
      S_EMIT:    w = '{op: OP_EMIT,    cond: C_OUT_FREE, tgt: S_WAIT};
      S_HOLD:    w = '{op: OP_NONE,    cond: C_ALWAYS,   tgt: S_EMIT};
      default:   w = '{op: OP_NONE,    cond: C_ALWAYS,   tgt: S_WAIT};
    endcase
    return w;
  endfunction

  // Powers of ten that fit a seed
  function automatic logic [SEED_W-1:0] pow_ten(input logic [DIGIT_W-1:0] k);
    logic [SEED_W-1:0] p;
    case (k)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/core/mprg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mprg_if: valid/ready channels of the middle-product random generator
// mprg_in_if carries command transactions, mprg_out_if result transactions.
// ----------------------------------------------------------------------------
interface mprg_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic advance;

  modport source (output valid, output restart, output advance, input ready);
  modport sink   (input valid, input restart, input advance, output ready);
endinterface

interface mprg_out_if import mprg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROD_W-1:0] product;
  logic [SEED_W-1:0] next_value;
  logic              seed_error;

  modport source (output valid, output product, output next_value,
                  output seed_error, input ready);
  modport sink   (input valid, input product, input next_value,
                  input seed_error, output ready);
endinterface
`default_nettype wire

### rtl/core/middle_product_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// middle_product_random_generator: decimal middle-product number generator
// A small control store sequences a multiplier, a binary-to-BCD shifter and
// a digit collector to produce one result transaction per command.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives exactly one result. An advance
// runs one multiply, 15 passes of the BCD conversion at 4 product bits per
// pass and one pass per output digit (D = digit_count). A restart runs the
// clear, load and emit steps, and an idle command or a refused advance runs
// the clear, check, fail and emit steps. A finished result waits in the
// output register, and the next command is taken meanwhile; the sequencer
// only waits when a new result is ready while the previous one has not yet
// been taken.
// Configuration writes land at once and are meant to be made while idle.
module middle_product_random_generator
  import mprg_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_idx,
  input  wire [CFG_W-1:0]      cfg_data,
  mprg_in_if.sink              in_ch,
  mprg_out_if.source           out_ch
);

  localparam int unsigned BCD_DIG = 2 * MAX_DIGITS;
  localparam int unsigned BCD_W   = 4 * BCD_DIG;
  localparam int unsigned IDX_W   = (BCD_DIG > 1) ? $clog2(BCD_DIG) : 1;
  localparam int unsigned LEN_W   = $clog2(BCD_DIG + 1);
  localparam int unsigned SUM_W   = ((LEN_W > DIGIT_W) ? LEN_W : DIGIT_W) + 1;

  // Configuration registers
  logic [SEED_W-1:0]  first_seed_r,  first_seed_nxt;
  logic [SEED_W-1:0]  second_seed_r, second_seed_nxt;
  logic [DIGIT_W-1:0] dc_r,          dc_nxt;

  // Generator state
  logic [SEED_W-1:0]  prev_r,   prev_nxt;
  logic [SEED_W-1:0]  cur_r,    cur_nxt;
  logic               seeded_r, seeded_nxt;

  // Sequencer and working registers
  logic [PC_W-1:0]    pc_r,      pc_nxt;
  logic               restart_r, restart_nxt;
  logic               advance_r, advance_nxt;
  logic [PROD_W-1:0]  prod_r,    prod_nxt;
  logic [PROD_W-1:0]  bin_r,     bin_nxt;
  logic [BCD_W-1:0]   bcd_r,     bcd_nxt;
  logic [SEED_W-1:0]  next_r,    next_nxt;
  logic               err_r,     err_nxt;
  logic [CNT_W-1:0]   cnt_r,     cnt_nxt;
  logic [IDX_W-1:0]   idx_r,     idx_nxt;

  // Output register
  logic               out_valid_r,  out_valid_nxt;
  logic [PROD_W-1:0]  out_prod_r,   out_prod_nxt;
  logic [SEED_W-1:0]  out_next_r,   out_next_nxt;
  logic               out_err_r,    out_err_nxt;

  // Combinational helpers
  uword_t             uw;
  logic               taken;
  logic               in_fire;
  logic               out_free;
  logic               d_ok;
  logic               seeds_ok;
  logic [SEED_W-1:0]  hi_bound;
  logic [SEED_W-1:0]  lo_bound;
  logic [PROD_W-1:0]  mul_c;
  logic [BCD_W-1:0]   dab_bcd;
  logic [PROD_W-1:0]  dab_bin;
  logic [LEN_W-1:0]   len_c;
  logic [SUM_W-1:0]   len_x;
  logic [SUM_W-1:0]   d_x;
  logic [SUM_W-1:0]   drop_x;
  logic [SUM_W-1:0]   top_x;
  logic [3:0]         digit_c;

  assign uw       = ucode(pc_r);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = (pc_r == S_WAIT);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.product    = out_prod_r;
  assign out_ch.next_value = out_next_r;
  assign out_ch.seed_error = out_err_r;

  // Digit count range and seed length checks
  assign d_ok     = (dc_r != '0) && (dc_r <= DIGIT_W'(MAX_DIGITS));
  assign hi_bound = pow_ten(dc_r);
  assign lo_bound = (dc_r == DIGIT_W'(1)) ? '0 : pow_ten(dc_r - DIGIT_W'(1));
  assign seeds_ok = d_ok
                    && (first_seed_r  >= lo_bound) && (first_seed_r  < hi_bound)
                    && (second_seed_r >= lo_bound) && (second_seed_r < hi_bound);

  // Multiplier: one 30 x 30 product, registered
  assign mul_c = PROD_W'(prev_r) * PROD_W'(cur_r);

  // Shift-and-add-3 conversion, several product bits per pass
  always_comb begin
    dab_bcd = bcd_r;
    dab_bin = bin_r;
    for (int s = 0; s < DABBLE_BITS; s++) begin
      for (int i = 0; i < BCD_DIG; i++) begin
        if (dab_bcd[4*i +: 4] >= 4'd5) begin
          dab_bcd[4*i +: 4] = dab_bcd[4*i +: 4] + 4'd3;
        end
      end
      {dab_bcd, dab_bin} = {dab_bcd[BCD_W-2:0], dab_bin, 1'b0};
    end
  end

  // Decimal length: position of the highest nonzero digit, at least one
  always_comb begin
    len_c = LEN_W'(1);
    for (int i = 1; i < BCD_DIG; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        len_c = LEN_W'(i + 1);
      end
    end
  end

  // Low digits to skip; a product shorter than D is taken whole
  assign len_x  = SUM_W'(len_c);
  assign d_x    = SUM_W'(dc_r);
  assign drop_x = (len_x < d_x) ? '0 : ((len_x - d_x + SUM_W'(1)) >> 1);
  assign top_x  = drop_x + d_x - SUM_W'(1);

  assign digit_c = bcd_r[4*idx_r +: 4];

  // Jump condition
  always_comb begin
    case (uw.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_INPUT: taken = !in_fire;
      C_RESTART:  taken = restart_r;
      C_NOGO:     taken = !advance_r || !seeded_r || !d_ok;
      C_LOOP:     taken = (cnt_r != CNT_W'(1));
      C_OUT_FREE: taken = out_free;
      default:    taken = 1'b1;
    endcase
  end

  assign pc_nxt = taken ? uw.tgt : pc_r + PC_W'(1);

  // Configuration writes
  always_comb begin
    first_seed_nxt  = first_seed_r;
    second_seed_nxt = second_seed_r;
    dc_nxt          = dc_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_FIRST_SEED:  first_seed_nxt  = cfg_data[SEED_W-1:0];
        CFG_SECOND_SEED: second_seed_nxt = cfg_data[SEED_W-1:0];
        CFG_DIGIT_COUNT: dc_nxt          = cfg_data[DIGIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath driven by the current control word
  always_comb begin
    restart_nxt   = restart_r;
    advance_nxt   = advance_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    seeded_nxt    = seeded_r;
    prod_nxt      = prod_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    next_nxt      = next_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_prod_nxt  = out_prod_r;
    out_next_nxt  = out_next_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r;

    // Capture the command transaction
    if (in_fire) begin
      restart_nxt = in_ch.restart;
      advance_nxt = in_ch.advance;
    end

    // Drop the result once it is taken
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (uw.op)
      OP_NONE: ;
      OP_CLEAR: begin
        prod_nxt = '0;
        next_nxt = '0;
        err_nxt  = 1'b0;
      end
      OP_MUL: begin
        prod_nxt = mul_c;
        bin_nxt  = mul_c;
        bcd_nxt  = '0;
        cnt_nxt  = CNT_W'(DABBLE_STEPS);
      end
      OP_DABBLE: begin
        bcd_nxt = dab_bcd;
        bin_nxt = dab_bin;
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_LEN: begin
        idx_nxt  = top_x[IDX_W-1:0];
        cnt_nxt  = CNT_W'(dc_r);
        next_nxt = '0;
      end
      OP_COLLECT: begin
        // next = next * 10 + digit, most significant digit first
        next_nxt = {next_r[SEED_W-4:0], 3'b000} + {next_r[SEED_W-2:0], 1'b0}
                   + SEED_W'(digit_c);
        idx_nxt  = idx_r - IDX_W'(1);
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
      OP_SHIFT: begin
        prev_nxt = cur_r;
        cur_nxt  = next_r;
      end
      OP_ERR: begin
        // idle commands are not errors, refused advances are
        err_nxt = advance_r;
      end
      OP_RESTART: begin
        if (seeds_ok) begin
          prev_nxt   = first_seed_r;
          cur_nxt    = second_seed_r;
          seeded_nxt = 1'b1;
        end else begin
          seeded_nxt = 1'b0;
          err_nxt    = 1'b1;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_prod_nxt  = prod_r;
          out_next_nxt  = next_r;
          out_err_nxt   = err_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= S_WAIT;
      out_valid_r   <= 1'b0;
      seeded_r      <= 1'b0;
      prev_r        <= '0;
      cur_r         <= '0;
      first_seed_r  <= FIRST_SEED_RST;
      second_seed_r <= SECOND_SEED_RST;
      dc_r          <= DIGIT_COUNT_RST;
    end else begin
      pc_r          <= pc_nxt;
      out_valid_r   <= out_valid_nxt;
      seeded_r      <= seeded_nxt;
      prev_r        <= prev_nxt;
      cur_r         <= cur_nxt;
      first_seed_r  <= first_seed_nxt;
      second_seed_r <= second_seed_nxt;
      dc_r          <= dc_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    restart_r  <= restart_nxt;
    advance_r  <= advance_nxt;
    prod_r     <= prod_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    next_r     <= next_nxt;
    err_r      <= err_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    out_prod_r <= out_prod_nxt;
    out_next_r <= out_next_nxt;
    out_err_r  <= out_err_nxt;
  end

endmodule
`default_nettype wire
